[design/pvar_pkg.sv]
// Shared constants, types and state codes for the pixel variance unit.
package pvar_pkg;

  localparam int unsigned MAX_PIXELS_DEF = 65536;
  localparam int unsigned PIX_W = 8;
  localparam int unsigned VAR_W = 14;
  localparam int unsigned MEAN_W = 8;
  localparam int unsigned STEP_W = 4;

  localparam logic [VAR_W-1:0]  VAR_MAX    = VAR_W'(16256);
  localparam logic [STEP_W-1:0] MEAN_STEPS = STEP_W'(MEAN_W - 1);
  localparam logic [STEP_W-1:0] VAR_STEPS  = STEP_W'(VAR_W - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEAN,
    ST_MUL_T,
    ST_SUB_U,
    ST_MUL_V,
    ST_SUB_D,
    ST_VAR,
    ST_DONE
  } pvar_state_t;

  typedef struct packed {
    logic start;
    logic ovf;
  } acc_ctl_t;

endpackage

[design/pvar_if.sv]
// Valid/ready channel interfaces for pixel input and variance results.
interface pvar_in_if import pvar_pkg::*;;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  logic             last;

  modport source (output valid, output pixel, output last, input ready);
  modport sink (input valid, input pixel, input last, output ready);
endinterface

interface pvar_out_if import pvar_pkg::*;;
  logic             valid;
  logic             ready;
  logic [VAR_W-1:0] variance;
  logic             overflow;

  modport source (output valid, output variance, output overflow, input ready);
  modport sink (input valid, input variance, input overflow, output ready);
endinterface

[design/pixel_variance_unit.sv]
// Top level of the pixel variance unit: accumulator plus shared-unit sequencer.
// Throughput: pixels stream at one per cycle while the sequencer is idle.
// After the last pixel's transfer the sequencer runs the mean division, the multiply and
// subtract states and the variance division, then loads the output register; input is
// stalled meanwhile. The shared subtractor yields one quotient bit per cycle.
// Reset (rst_n low, synchronous) clears accumulator sums, count, overflow flag and out valid.
module pixel_variance_unit import pvar_pkg::*; #(
  parameter int unsigned MaxPixels = MAX_PIXELS_DEF,
  localparam int unsigned CntW = $clog2(MaxPixels + 1),
  localparam int unsigned SumW = CntW + PIX_W,
  localparam int unsigned SqW  = CntW + 2 * PIX_W
) (
  input logic             clk,
  input logic             rst_n,
  pvar_in_if.sink         in_s,
  pvar_out_if.source      out_m
);

  logic            accept;
  logic            idle;
  acc_ctl_t        ctl;
  logic [SumW-1:0] sum_tot;
  logic [SqW-1:0]  sq_tot;
  logic [CntW-1:0] cnt_tot;

  // Pixels are taken whenever the sequencer is idle. A finished result can still sit in
  // the output register, because the sequencer waits in its final state for a free slot.
  assign in_s.ready = idle;
  assign accept     = in_s.valid && idle;

  // The accumulator hands its updated totals to the sequencer on the last pixel's
  // transfer and clears itself in the same cycle.
  pvar_accum #(.MaxPixels(MaxPixels)) u_accum (
    .clk     (clk),
    .rst_n   (rst_n),
    .accept  (accept),
    .pixel   (in_s.pixel),
    .last    (in_s.last),
    .sum_tot (sum_tot),
    .sq_tot  (sq_tot),
    .cnt_tot (cnt_tot),
    .ctl     (ctl)
  );

  // The sequencer divides for the mean, forms the squared deviation total as
  // sumsq - mean * (2 * sum - count * mean), then divides by the count again.
  pvar_calc #(.MaxPixels(MaxPixels)) u_calc (
    .clk          (clk),
    .rst_n        (rst_n),
    .ctl          (ctl),
    .sum_tot      (sum_tot),
    .sq_tot       (sq_tot),
    .cnt_tot      (cnt_tot),
    .idle         (idle),
    .out_valid    (out_m.valid),
    .out_ready    (out_m.ready),
    .out_variance (out_m.variance),
    .out_overflow (out_m.overflow)
  );

  a_busy_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (in_s.valid && in_s.ready && in_s.last) |=> !in_s.ready)
    else $error("input still ready while the variance is computed");

endmodule

[design/pvar_accum.sv]
// Running pixel sum, square sum and count with the overflow flag.
module pvar_accum import pvar_pkg::*; #(
  parameter int unsigned MaxPixels = MAX_PIXELS_DEF,
  localparam int unsigned CntW = $clog2(MaxPixels + 1),
  localparam int unsigned SumW = CntW + PIX_W,
  localparam int unsigned SqW  = CntW + 2 * PIX_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  logic [PIX_W-1:0] pixel,
  input  logic             last,
  output logic [SumW-1:0]  sum_tot,
  output logic [SqW-1:0]   sq_tot,
  output logic [CntW-1:0]  cnt_tot,
  output acc_ctl_t         ctl
);

  logic [SumW-1:0]    sum_r, sum_nxt;
  logic [SqW-1:0]     sq_r, sq_nxt;
  logic [CntW-1:0]    cnt_r, cnt_nxt;
  logic               ovf_r, ovf_nxt;
  logic               ovf_tot;
  logic               room;
  logic [2*PIX_W-1:0] psq;

  assign psq  = pixel * pixel;
  assign room = cnt_r < CntW'(MaxPixels);

  always_comb begin
    sum_tot = sum_r;
    sq_tot  = sq_r;
    cnt_tot = cnt_r;
    ovf_tot = ovf_r;
    if (accept) begin
      if (room) begin
        sum_tot = sum_r + SumW'(pixel);
        sq_tot  = sq_r + SqW'(psq);
        cnt_tot = cnt_r + CntW'(1);
      end else begin
        ovf_tot = 1'b1;
      end
    end
    ctl.start = accept && last;
    ctl.ovf   = ovf_tot;
    // The image closes on its last pixel: the totals move on and we start over.
    if (ctl.start) begin
      sum_nxt = '0;
      sq_nxt  = '0;
      cnt_nxt = '0;
      ovf_nxt = 1'b0;
    end else begin
      sum_nxt = sum_tot;
      sq_nxt  = sq_tot;
      cnt_nxt = cnt_tot;
      ovf_nxt = ovf_tot;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      sq_r  <= '0;
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      sum_r <= sum_nxt;
      sq_r  <= sq_nxt;
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
    end
  end

  a_cnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CntW'(MaxPixels))
    else $error("pixel count exceeds the image limit");

endmodule

[design/pvar_alu.sv]
// Shared arithmetic unit: one subtractor with borrow and one narrow multiplier.
module pvar_alu import pvar_pkg::*; #(
  parameter int unsigned MaxPixels = MAX_PIXELS_DEF,
  localparam int unsigned CntW = $clog2(MaxPixels + 1),
  localparam int unsigned SumW = CntW + PIX_W,
  localparam int unsigned SqW  = CntW + 2 * PIX_W,
  localparam int unsigned MulW = SumW + 1,
  localparam int unsigned ProdW = MulW + MEAN_W
) (
  input  logic [SqW-1:0]    sub_a,
  input  logic [SqW-1:0]    sub_b,
  output logic [SqW-1:0]    diff,
  output logic              borrow,
  input  logic [MEAN_W-1:0] mul_a,
  input  logic [MulW-1:0]   mul_b,
  output logic [ProdW-1:0]  prod
);

  logic [SqW:0] wide_diff;

  assign wide_diff = {1'b0, sub_a} - {1'b0, sub_b};
  assign diff      = wide_diff[SqW-1:0];
  assign borrow    = wide_diff[SqW];
  assign prod      = ProdW'(mul_a) * ProdW'(mul_b);

endmodule

[design/pvar_calc.sv]
// Sequencer that runs mean, deviation total and variance through the shared unit.
module pvar_calc import pvar_pkg::*; #(
  parameter int unsigned MaxPixels = MAX_PIXELS_DEF,
  localparam int unsigned CntW = $clog2(MaxPixels + 1),
  localparam int unsigned SumW = CntW + PIX_W,
  localparam int unsigned SqW  = CntW + 2 * PIX_W,
  localparam int unsigned MulW = SumW + 1,
  localparam int unsigned ProdW = MulW + MEAN_W
) (
  input  logic             clk,
  input  logic             rst_n,
  input  acc_ctl_t         ctl,
  input  logic [SumW-1:0]  sum_tot,
  input  logic [SqW-1:0]   sq_tot,
  input  logic [CntW-1:0]  cnt_tot,
  output logic             idle,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [VAR_W-1:0] out_variance,
  output logic             out_overflow
);

  pvar_state_t       st_r, st_nxt;
  logic [SumW-1:0]   sum_r, sum_nxt;
  logic [SqW-1:0]    sq_r, sq_nxt;
  logic [CntW-1:0]   cnt_r, cnt_nxt;
  logic [SqW-1:0]    rem_r, rem_nxt;
  logic [VAR_W-1:0]  quo_r, quo_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [ProdW-1:0]  prod_r, prod_nxt;
  logic              ovf_r, ovf_nxt;
  logic              vld_r, vld_nxt;
  logic [VAR_W-1:0]  var_r, var_nxt;
  logic              oflag_r, oflag_nxt;

  logic [SqW-1:0]    sub_a, sub_b, diff;
  logic              borrow;
  logic [MulW-1:0]   mul_b;
  logic [ProdW-1:0]  prod;
  logic [SqW-1:0]    div_sh;

  assign div_sh = SqW'(cnt_r) << step_r;

  always_comb begin
    unique case (st_r)
      ST_SUB_U: begin
        sub_a = SqW'({sum_r, 1'b0});
        sub_b = SqW'(prod_r[SumW-1:0]);
      end
      ST_SUB_D: begin
        sub_a = sq_r;
        sub_b = prod_r[SqW-1:0];
      end
      default: begin
        sub_a = rem_r;
        sub_b = div_sh;
      end
    endcase
    mul_b = (st_r == ST_MUL_V) ? rem_r[MulW-1:0] : MulW'(cnt_r);
  end

  pvar_alu #(.MaxPixels(MaxPixels)) u_alu (
    .sub_a  (sub_a),
    .sub_b  (sub_b),
    .diff   (diff),
    .borrow (borrow),
    .mul_a  (quo_r[MEAN_W-1:0]),
    .mul_b  (mul_b),
    .prod   (prod)
  );

  always_comb begin
    st_nxt    = st_r;
    sum_nxt   = sum_r;
    sq_nxt    = sq_r;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    step_nxt  = step_r;
    prod_nxt  = prod_r;
    ovf_nxt   = ovf_r;
    var_nxt   = var_r;
    oflag_nxt = oflag_r;
    vld_nxt   = vld_r && !out_ready;
    unique case (st_r)
      ST_IDLE: begin
        if (ctl.start) begin
          sum_nxt  = sum_tot;
          sq_nxt   = sq_tot;
          cnt_nxt  = cnt_tot;
          ovf_nxt  = ctl.ovf;
          rem_nxt  = SqW'(sum_tot);
          quo_nxt  = '0;
          step_nxt = MEAN_STEPS;
          st_nxt   = ST_MEAN;
        end
      end
      ST_MEAN, ST_VAR: begin
        // Restoring long division, one quotient bit per cycle.
        if (!borrow) begin
          rem_nxt = diff;
        end
        quo_nxt  = {quo_r[VAR_W-2:0], !borrow};
        step_nxt = step_r - STEP_W'(1);
        if (step_r == '0) begin
          st_nxt = (st_r == ST_MEAN) ? ST_MUL_T : ST_DONE;
        end
      end
      ST_MUL_T: begin
        prod_nxt = prod;
        st_nxt   = ST_SUB_U;
      end
      ST_SUB_U: begin
        rem_nxt = diff;
        st_nxt  = ST_MUL_V;
      end
      ST_MUL_V: begin
        prod_nxt = prod;
        st_nxt   = ST_SUB_D;
      end
      ST_SUB_D: begin
        rem_nxt  = diff;
        quo_nxt  = '0;
        step_nxt = VAR_STEPS;
        st_nxt   = ST_VAR;
      end
      ST_DONE: begin
        if (!vld_r || out_ready) begin
          var_nxt   = quo_r;
          oflag_nxt = ovf_r;
          vld_nxt   = 1'b1;
          st_nxt    = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r  <= ST_IDLE;
      vld_r <= 1'b0;
    end else begin
      st_r  <= st_nxt;
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r   <= sum_nxt;
    sq_r    <= sq_nxt;
    cnt_r   <= cnt_nxt;
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    step_r  <= step_nxt;
    prod_r  <= prod_nxt;
    ovf_r   <= ovf_nxt;
    var_r   <= var_nxt;
    oflag_r <= oflag_nxt;
  end

  assign idle         = (st_r == ST_IDLE);
  assign out_valid    = vld_r;
  assign out_variance = var_r;
  assign out_overflow = oflag_r;

  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_MEAN || st_r == ST_VAR) |-> cnt_r != '0)
    else $error("division started with a zero pixel count");

  a_mean_steps: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == ST_MEAN |-> step_r <= MEAN_STEPS)
    else $error("mean division ran past eight steps");

  a_var_range: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(vld_r) |-> var_r <= VAR_MAX)
    else $error("variance result out of range");

endmodule
